// ----- rtl/core/drhd_pkg.sv -----
// Shared types and constants for the delimited RTP to H.264 depacketizer.
package drhd_pkg;

  localparam logic [31:0] DELIM_RESET = 32'h43444546;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_DELIM = 3'd1;
  localparam logic [2:0] ERR_MODE     = 3'd2;
  localparam logic [2:0] ERR_SHORT    = 3'd3;
  localparam logic [2:0] ERR_FU_TYPE  = 3'd4;

  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_FU_A   = 2'd2;
  localparam logic [4:0] FU_A_TYPE   = 5'd28;

  localparam logic [3:0] OFF_NAL_HDR = 4'd12;
  localparam logic [3:0] OFF_FU_HDR  = 4'd13;
  localparam logic [3:0] OFF_PAYLOAD = 4'd14;
  localparam logic [3:0] OFF_MAX     = 4'd15;

  localparam logic [2:0] DELIM_LEN = 3'd4;

  localparam int CMD_DEPTH = 8;
  localparam int CMD_AW    = $clog2(CMD_DEPTH);

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_PKT   = 3'b010,
    PH_HUNT  = 3'b100
  } phase_t;

  // One command per packet byte that produces output, and one per error report.
  typedef struct packed {
    logic       start;
    logic       is_data;
    logic [7:0] data;
    logic       last;
    logic [2:0] err;
  } cmd_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       byte_valid;
    logic       last;
    logic [2:0] err;
  } res_t;

endpackage

// ----- rtl/core/delimited_rtp_h264_depacketizer.sv -----
// Top level of the delimited RTP to H.264 Annex B depacketizer.
// A packet byte leaves the window when the fourth byte after it is accepted; its first result
// passes through the command queue and the output register before reaching the ports.
// Throughput: one input byte per cycle unless in_full; one result per cycle while out_pop.
// Start commands (single NAL header, FU-A start fragment) expand to five results, absorbed by the
// eight-entry command queue. Reset (synchronous, rst_n low) clears the window, parser state and
// queues and restores the delimiter to ASCII CDEF.
module delimited_rtp_h264_depacketizer
  import drhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_last_of_packet,
  output logic [2:0]  out_error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_delimiter_word
);

  logic accept;
  logic cmd_push, fifo_full, head_valid, head_pop, res_valid, res_pop;
  cmd_t cmd, head_cmd;
  res_t res;

  assign in_full   = fifo_full;
  assign accept    = in_push && !fifo_full;
  assign cfg_ready = 1'b1;

  drhd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_byte  (in_byte),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_delimiter_word),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  drhd_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .full       (fifo_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  drhd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .head_pop   (head_pop),
    .res_valid  (res_valid),
    .res        (res),
    .res_pop    (res_pop)
  );

  assign res_pop            = out_pop && res_valid;
  assign out_empty          = !res_valid;
  assign out_byte           = res.byte_val;
  assign out_byte_valid     = res.byte_valid;
  assign out_last_of_packet = res.last;
  assign out_error_code     = res.err;

endmodule

// ----- rtl/core/drhd_front.sv -----
// Front end: delimiter window, packet parsing and command generation.
module drhd_front
  import drhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic        cmd_push,
  output cmd_t        cmd
);

  logic [31:0] delim_r;
  logic [7:0]  win_r [4];
  phase_t      phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [3:0]  offset_r, offset_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [2:0]  fnri_r, fnri_nxt;
  logic        drop_r, drop_nxt;

  logic [31:0] word;
  logic        match, pkt_end, is_short;
  logic [7:0]  oldest;
  logic [3:0]  off_inc;

  assign oldest  = win_r[0];
  assign word    = {win_r[1], win_r[2], win_r[3], in_byte};
  assign match   = (word == delim_r);
  assign off_inc = (offset_r == OFF_MAX) ? offset_r : offset_r + 4'd1;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    offset_nxt = offset_r;
    mode_nxt   = mode_r;
    fnri_nxt   = fnri_r;
    drop_nxt   = drop_r;
    cmd_push   = 1'b0;
    cmd        = '0;
    pkt_end    = 1'b0;
    is_short   = 1'b0;
    unique case (phase_r)
      PH_START: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_nxt >= DELIM_LEN) begin
          if (match) begin
            phase_nxt = PH_PKT;
            pkt_end   = 1'b1;
          end else begin
            phase_nxt = PH_HUNT;
            cnt_nxt   = 3'd0;
            cmd_push  = 1'b1;
            cmd.err   = ERR_NO_DELIM;
          end
        end
      end
      PH_HUNT: begin
        if (match) begin
          phase_nxt = PH_PKT;
          pkt_end   = 1'b1;
        end
      end
      PH_PKT: begin
        if (cnt_r != 3'd0) begin
          cnt_nxt = cnt_r - 3'd1;
        end else if (!drop_r) begin
          offset_nxt = off_inc;
          if (offset_r == 4'd0) begin
            mode_nxt = oldest[7:6];
            if (mode_nxt != MODE_SINGLE && mode_nxt != MODE_FU_A) begin
              drop_nxt = 1'b1;
              cmd_push = 1'b1;
              cmd.err  = ERR_MODE;
            end
          end else if (offset_r >= OFF_NAL_HDR) begin
            if (mode_r == MODE_SINGLE) begin
              cmd_push    = 1'b1;
              cmd.is_data = 1'b1;
              cmd.data    = oldest;
              cmd.start   = (offset_r == OFF_NAL_HDR);
            end else if (offset_r == OFF_NAL_HDR) begin
              if (oldest[4:0] != FU_A_TYPE) begin
                drop_nxt = 1'b1;
                cmd_push = 1'b1;
                cmd.err  = ERR_FU_TYPE;
              end else begin
                fnri_nxt = oldest[7:5];
              end
            end else if (offset_r == OFF_FU_HDR) begin
              if (oldest[7]) begin
                cmd_push    = 1'b1;
                cmd.is_data = 1'b1;
                cmd.start   = 1'b1;
                cmd.data    = {fnri_r, oldest[4:0]};
              end
            end else begin
              cmd_push    = 1'b1;
              cmd.is_data = 1'b1;
              cmd.data    = oldest;
            end
          end
        end
        // A delimiter counts only once the previous one has left the window.
        if (match && cnt_nxt == 3'd0) begin
          cmd.last = cmd.is_data;
          is_short = (offset_nxt == 4'd0) ||
                     (mode_nxt == MODE_SINGLE && offset_nxt < OFF_FU_HDR) ||
                     (mode_nxt == MODE_FU_A && offset_nxt < OFF_PAYLOAD);
          if (!drop_nxt && is_short) begin
            cmd_push = 1'b1;
            cmd.err  = ERR_SHORT;
          end
          pkt_end = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_START;
      end
    endcase
    if (pkt_end) begin
      cnt_nxt    = DELIM_LEN;
      offset_nxt = 4'd0;
      mode_nxt   = 2'd0;
      fnri_nxt   = 3'd0;
      drop_nxt   = 1'b0;
    end
    if (!accept) begin
      cmd_push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r  <= DELIM_RESET;
      win_r    <= '{default: 8'd0};
      phase_r  <= PH_START;
      cnt_r    <= 3'd0;
      offset_r <= 4'd0;
      mode_r   <= 2'd0;
      fnri_r   <= 3'd0;
      drop_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        delim_r <= cfg_data;
      end
      if (accept) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= win_r[3];
        win_r[3] <= in_byte;
        phase_r  <= phase_nxt;
        cnt_r    <= cnt_nxt;
        offset_r <= offset_nxt;
        mode_r   <= mode_nxt;
        fnri_r   <= fnri_nxt;
        drop_r   <= drop_nxt;
      end
    end
  end

endmodule

// ----- rtl/core/drhd_cmd_fifo.sv -----
// Short command queue between the front end and the output sequencer.
module drhd_cmd_fifo
  import drhd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              mem_r [CMD_DEPTH];
  logic [CMD_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_AW:0]   count_r;

  assign full       = (count_r == (CMD_AW+1)'(CMD_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- rtl/core/drhd_back.sv -----
// Output sequencer: expands commands into start codes, data bytes and error reports.
module drhd_back
  import drhd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic head_valid,
  input  cmd_t head_cmd,
  output logic head_pop,
  output logic res_valid,
  output res_t res,
  input  logic res_pop
);

  logic [2:0] ph_r, ph_nxt;
  logic       res_valid_r, res_valid_nxt;
  res_t       res_r, res_nxt;
  logic       advance;
  logic       emit_start;

  assign advance    = !res_valid_r || res_pop;
  assign emit_start = head_cmd.start && (ph_r != DELIM_LEN);

  always_comb begin
    ph_nxt        = ph_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_pop;
    head_pop      = 1'b0;
    if (advance && head_valid) begin
      res_valid_nxt = 1'b1;
      if (emit_start) begin
        // Annex B start code 00 00 00 01 ahead of the NAL header byte.
        res_nxt.byte_val   = (ph_r == DELIM_LEN - 3'd1) ? 8'd1 : 8'd0;
        res_nxt.byte_valid = 1'b1;
        res_nxt.last       = 1'b0;
        res_nxt.err        = ERR_NONE;
        ph_nxt             = ph_r + 3'd1;
      end else begin
        res_nxt.byte_val   = head_cmd.is_data ? head_cmd.data : 8'd0;
        res_nxt.byte_valid = head_cmd.is_data;
        res_nxt.last       = head_cmd.is_data && head_cmd.last;
        res_nxt.err        = head_cmd.is_data ? ERR_NONE : head_cmd.err;
        ph_nxt             = 3'd0;
        head_pop           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (!rst_n) begin
      ph_r        <= 3'd0;
      res_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ----- sim/tb_delimited_rtp_h264_depacketizer.sv -----
// Self-checking testbench for the delimited RTP to H.264 depacketizer.
module tb_delimited_rtp_h264_depacketizer;
  timeunit 1ns;
  timeprecision 1ps;
  import drhd_pkg::*;

  localparam int RANDOM_FILL    = -1;
  localparam int SEND_PER_PHASE = 16;
  localparam int DRAIN_CYCLES   = 12;

  // Header modes that the block must reject.
  localparam logic [1:0] MODE_BAD_LOW  = 2'd0;
  localparam logic [1:0] MODE_BAD_HIGH = 2'd3;

  logic        clk;
  logic        rst_n              = 1'b0;
  logic        in_push            = 1'b0;
  logic        in_full;
  logic [7:0]  in_byte            = '0;
  logic        out_empty;
  logic        out_pop            = 1'b0;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_last_of_packet;
  logic [2:0]  out_error_code;
  logic        cfg_valid          = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_delimiter_word = '0;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int bytes_sent = 0;
  int beats_seen = 0;
  int delim_writes = 0;
  int errors = 0;

  // Output beats still owed by the block, oldest first.
  res_t annexb_q[$];

  // Predictor state.
  logic [31:0] delim_word;
  logic [7:0]  win [4];
  phase_t      scan_phase;
  logic [2:0]  skip_cnt;
  logic [3:0]  pkt_off;
  logic [1:0]  pkt_mode;
  logic [2:0]  fu_fnri;
  logic        pkt_drop;

  delimited_rtp_h264_depacketizer u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_byte            (in_byte),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_last_of_packet (out_last_of_packet),
    .out_error_code     (out_error_code),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_delimiter_word (cfg_delimiter_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void push_beat(logic [7:0] b, logic v, logic l, logic [2:0] e);
    res_t r;
    r.byte_val   = b;
    r.byte_valid = v;
    r.last       = l;
    r.err        = e;
    annexb_q.push_back(r);
  endfunction

  function automatic void push_start_code();
    push_beat(8'h00, 1'b1, 1'b0, ERR_NONE);
    push_beat(8'h00, 1'b1, 1'b0, ERR_NONE);
    push_beat(8'h00, 1'b1, 1'b0, ERR_NONE);
    push_beat(8'h01, 1'b1, 1'b0, ERR_NONE);
  endfunction

  function automatic void open_packet();
    skip_cnt = DELIM_LEN;
    pkt_off  = '0;
    pkt_mode = '0;
    fu_fnri  = '0;
    pkt_drop = 1'b0;
  endfunction

  function automatic void clear_predictor();
    delim_word = DELIM_RESET;
    for (int i = 0; i < 4; i++) win[i] = '0;
    scan_phase = PH_START;
    open_packet();
    skip_cnt = '0;
  endfunction

  // One packet byte leaving the window; last is set when the delimiter behind it completed.
  function automatic void parse_packet_byte(logic [7:0] b, logic last);
    logic [3:0] off;
    off = pkt_off;
    if (pkt_drop) return;
    if (pkt_off < OFF_MAX) pkt_off++;
    if (off == 0) begin
      pkt_mode = b[7:6];
      if (pkt_mode != MODE_SINGLE && pkt_mode != MODE_FU_A) begin
        pkt_drop = 1'b1;
        push_beat(8'h00, 1'b0, 1'b0, ERR_MODE);
      end
    end else if (off >= OFF_NAL_HDR) begin
      if (pkt_mode == MODE_SINGLE) begin
        if (off == OFF_NAL_HDR) push_start_code();
        push_beat(b, 1'b1, last, ERR_NONE);
      end else if (off == OFF_NAL_HDR) begin
        if (b[4:0] != FU_A_TYPE) begin
          pkt_drop = 1'b1;
          push_beat(8'h00, 1'b0, 1'b0, ERR_FU_TYPE);
        end else begin
          fu_fnri = b[7:5];
        end
      end else if (off == OFF_FU_HDR) begin
        // Only a start fragment rebuilds the NAL header.
        if (b[7]) begin
          push_start_code();
          push_beat({fu_fnri, b[4:0]}, 1'b1, last, ERR_NONE);
        end
      end else begin
        push_beat(b, 1'b1, last, ERR_NONE);
      end
    end
  endfunction

  function automatic void depacketize_byte(logic [7:0] b);
    logic [7:0] leaving;
    logic       hit;
    logic       skipping;
    logic       short_pkt;
    leaving = win[0];
    win[0]  = win[1];
    win[1]  = win[2];
    win[2]  = win[3];
    win[3]  = b;
    hit = ({win[0], win[1], win[2], win[3]} == delim_word);
    case (scan_phase)
      PH_START: begin
        skip_cnt = skip_cnt + 3'd1;
        if (skip_cnt >= DELIM_LEN) begin
          if (hit) begin
            scan_phase = PH_PKT;
            open_packet();
          end else begin
            scan_phase = PH_HUNT;
            skip_cnt   = '0;
            push_beat(8'h00, 1'b0, 1'b0, ERR_NO_DELIM);
          end
        end
      end
      PH_HUNT: begin
        if (hit) begin
          scan_phase = PH_PKT;
          open_packet();
        end
      end
      default: begin
        // Delimiter bytes still in the window are neither data nor part of a new match.
        skipping = (skip_cnt != 0);
        if (skipping) skip_cnt--;
        hit = hit && (skip_cnt == 0);
        if (!skipping) parse_packet_byte(leaving, hit);
        if (hit) begin
          short_pkt = (pkt_off == 0) ||
                      (pkt_mode == MODE_SINGLE && pkt_off < OFF_FU_HDR) ||
                      (pkt_mode == MODE_FU_A && pkt_off < OFF_PAYLOAD);
          if (!pkt_drop && short_pkt) push_beat(8'h00, 1'b0, 1'b0, ERR_SHORT);
          open_packet();
        end
      end
    endcase
  endfunction

  always @(negedge clk) begin
    out_pop <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      beats_seen++;
      if (annexb_q.size() == 0) begin
        $error("unexpected output beat: out_byte %02h out_error_code %0d",
               out_byte, out_error_code);
        errors++;
      end else begin
        want = annexb_q.pop_front();
        if (out_byte !== want.byte_val) begin
          $error("out_byte: expected %02h, actual %02h", want.byte_val, out_byte);
          errors++;
        end
        if (out_byte_valid !== want.byte_valid) begin
          $error("out_byte_valid: expected %0b, actual %0b", want.byte_valid, out_byte_valid);
          errors++;
        end
        if (out_last_of_packet !== want.last) begin
          $error("out_last_of_packet: expected %0b, actual %0b", want.last, out_last_of_packet);
          errors++;
        end
        if (out_error_code !== want.err) begin
          $error("out_error_code: expected %0d, actual %0d", want.err, out_error_code);
          errors++;
        end
      end
    end
  end

  // Entered and left just after a falling edge.
  task automatic push_byte(input logic [7:0] b);
    if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_push <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_full);
    depacketize_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_delimiter();
    for (int i = 3; i >= 0; i--) push_byte(delim_word[i*8 +: 8]);
  endtask

  // Byte 0 carries the mode, bytes 12 and 13 the NAL and FU headers, the rest the fill.
  task automatic send_packet(input logic [1:0] mode, input int len, input logic [7:0] nal_hdr,
                             input logic [7:0] fu_hdr, input int fill);
    logic [7:0] v;
    for (int i = 0; i < len; i++) begin
      v = (fill < 0) ? 8'($urandom) : 8'(fill);
      if (i == 0) v[7:6] = mode;
      else if (i == OFF_NAL_HDR) v = nal_hdr;
      else if (i == OFF_FU_HDR) v = fu_hdr;
      push_byte(v);
    end
    send_delimiter();
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (annexb_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_delimiter(input logic [31:0] w);
    drain();
    cfg_valid          <= 1'b1;
    cfg_delimiter_word <= w;
    do @(posedge clk); while (!cfg_ready);
    delim_word = w;
    delim_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  task automatic test_startup_mismatch();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h43);
    push_byte(8'h45);
    push_byte(8'h44);
    push_byte(8'h46);
    send_delimiter();
  endtask

  task automatic test_single_nal();
    send_packet(MODE_SINGLE, 14, 8'h65, 8'h00, RANDOM_FILL);
  endtask

  task automatic test_fu_a();
    send_packet(MODE_FU_A, 15, 8'hFC, 8'h85, RANDOM_FILL);
    send_packet(MODE_FU_A, 14, 8'h7C, 8'h05, RANDOM_FILL);
  endtask

  task automatic test_malformed();
    send_packet(MODE_BAD_LOW, 3, 8'h65, 8'h01, RANDOM_FILL);
    send_packet(MODE_BAD_HIGH, 2, 8'h65, 8'h01, RANDOM_FILL);
    send_packet(MODE_SINGLE, 12, 8'h65, 8'h01, RANDOM_FILL);
    send_packet(MODE_FU_A, 13, 8'hFC, 8'h85, RANDOM_FILL);
    send_packet(MODE_FU_A, 13, 8'h7D, 8'h85, RANDOM_FILL);
  endtask

  task automatic test_delimiter_settings();
    write_delimiter(32'h0000_0000);
    send_packet(MODE_SINGLE, 13, 8'h41, 8'h7F, 8'hFF);
    // Zeros right after a zero delimiter overlap it and must not match until four new ones
    // have arrived; those close an empty packet.
    send_delimiter();
    write_delimiter(DELIM_RESET);
  endtask

  task automatic send_random_packet();
    int         kind;
    logic [7:0] nal_hdr;
    logic [7:0] fu_hdr;
    kind    = $urandom_range(0, 9);
    nal_hdr = 8'($urandom);
    fu_hdr  = 8'($urandom);
    if (kind < 4) begin
      send_packet(MODE_SINGLE, $urandom_range(13, 18), nal_hdr, fu_hdr, RANDOM_FILL);
    end else if (kind < 7) begin
      nal_hdr[4:0] = FU_A_TYPE;
      send_packet(MODE_FU_A, $urandom_range(14, 18), nal_hdr, fu_hdr, RANDOM_FILL);
    end else if (kind == 7) begin
      send_packet(MODE_FU_A, $urandom_range(13, 16), nal_hdr, fu_hdr, RANDOM_FILL);
    end else begin
      send_packet(2'($urandom), $urandom_range(0, 15), nal_hdr, fu_hdr, RANDOM_FILL);
    end
  endtask

  task automatic run_random_phase(input int sender_pct, input int receiver_pct);
    int target;
    set_idling(sender_pct, receiver_pct);
    target = bytes_sent + SEND_PER_PHASE;
    while (bytes_sent < target) send_random_packet();
  endtask

  task automatic test_random();
    write_delimiter(32'($urandom));
    run_random_phase(12, 12);
    write_delimiter(DELIM_RESET);
  endtask

  initial begin
    clear_predictor();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_idling(0, 0);
    test_startup_mismatch();
    test_single_nal();
    set_idling(48, 0);
    test_fu_a();
    set_idling(0, 48);
    test_malformed();
    set_idling(12, 12);
    test_delimiter_settings();
    test_random();
    drain();

    $display("Sent %0d stream bytes across %0d delimiter writes and four idling mixes.",
             bytes_sent, delim_writes);
    $display("Checked %0d output beats against the predicted Annex B stream.", beats_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/drhd_pkg.sv
rtl/core/drhd_front.sv
rtl/core/drhd_cmd_fifo.sv
rtl/core/drhd_back.sv
rtl/core/delimited_rtp_h264_depacketizer.sv
sim/tb_delimited_rtp_h264_depacketizer.sv
